FILE: design/sweep_range_gated_distance_average_assert.svh
// Assertion helpers for the sweep range averager.
`ifndef SWEEP_RANGE_GATED_DISTANCE_AVERAGE_ASSERT_SVH
`define SWEEP_RANGE_GATED_DISTANCE_AVERAGE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SRGDA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srgda assertion failed");
// next-cycle implication
`define SRGDA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srgda assertion failed");
`else
`define SRGDA_ASSERT_IMP(label, ante, cons)
`define SRGDA_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: design/srgda_pkg.sv
package srgda_pkg;

  localparam int TICKS_PER_CM = 116;
  localparam int COLUMNS      = 8;
  localparam int ROWS         = 8;

  localparam int TICKS_W   = 16;
  localparam int SAMPLES_W = 7;
  localparam int CM_W      = 6;
  localparam int POS_W     = 3;
  localparam int SUM_W     = 13;
  localparam int HITS_W    = 7;
  localparam int HEIGHT_W  = 4;

  localparam int DIVIDEND_W = TICKS_W;
  localparam int DIVISOR_W  = HITS_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // ticks / TICKS_PER_CM as a multiply by the rounded-up reciprocal; with the
  // shift at input width plus clog2 of the divisor it is exact for every input
  localparam int CM_SHIFT  = TICKS_W + $clog2(TICKS_PER_CM);
  localparam int RECIP_W   = TICKS_W + 1;
  localparam int CM_PROD_W = TICKS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] CM_RECIP =
    RECIP_W'(((64'd1 << CM_SHIFT) + TICKS_PER_CM - 1) / TICKS_PER_CM);

  // average at or above this gives a full bar
  localparam int HEIGHT_SAT = 3 * ROWS + 3;

  localparam logic [SAMPLES_W-1:0] SAMPLES_RST  = 7'd100;
  localparam logic [CM_W-1:0]      MIN_CM_RST   = 6'd3;
  localparam logic [CM_W-1:0]      MAX_CM_RST   = 6'd24;
  localparam logic [POS_W-1:0]     LAST_POS_RST = 3'd7;
  localparam logic [POS_W-1:0]     POSITION_RST = 3'd3;

  typedef enum logic [1:0] {
    REG_SAMPLES  = 2'd0,
    REG_MIN_CM   = 2'd1,
    REG_MAX_CM   = 2'd2,
    REG_LAST_POS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_AVG,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // avg / 3 saturated to ROWS; below the knee avg*11 >> 5 equals avg / 3
  function automatic logic [HEIGHT_W-1:0] div3_sat(input logic [DIVIDEND_W-1:0] avg);
    logic [9:0] prod;
    prod = {5'd0, avg[4:0]} * 10'd11;
    if (avg >= DIVIDEND_W'(HEIGHT_SAT)) begin
      return HEIGHT_W'(ROWS);
    end
    return prod[8:5];
  endfunction

endpackage

FILE: design/srgda_div.sv
module srgda_div
  import srgda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // one restoring step per cycle, MSB first
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: design/sweep_range_gated_distance_average.sv
// Sweep range gated distance averager.
// in_*  : one echo width in timer ticks per request (in_tdata[15:0]).
// out_* : one result per input request. out_tdata = {height[3:0], column[2:0],
//         in_range}; out_tuser[0] = column_valid (last sample of a group).
// cfg_* : APB registers at 0x0 samples_per_position, 0x4 min_cm,
//         0x8 max_cm, 0xC last_position; write in the access phase, pready tied high.
// ticks / TICKS_PER_CM is a reciprocal multiply registered at accept. One
// 16-step serial divider forms sum / hits on a group-ending sample that had hits.
// From accept an item passes ST_ACCUM, then ST_DIV_AVG on a group end with hits, then
// ST_FINISH into the output register; in_tready comes back together with out_tvalid,
// so a new request waits for the last result; the divider, at one quotient bit
// per cycle, sets the longer path. The result waits in an output register: a
// stalled receiver does not block the next input, only the finish of that item.
// Reset (rst_n low at a clock edge) loads register defaults, position 3
// moving upward, and clears the running sum, hit and sample counts.
module sweep_range_gated_distance_average
  import srgda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // echo_ticks[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // {height[3:0], column[2:0], in_range}
  output logic [0:0]  out_tuser   // column_valid
);

  `include "sweep_range_gated_distance_average_assert.svh"

  logic [SAMPLES_W-1:0] spp_r;
  logic [CM_W-1:0]      min_r;
  logic [CM_W-1:0]      max_r;
  logic [POS_W-1:0]     last_pos_r;

  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     position_r, position_nxt;
  logic                 moving_down_r, moving_down_nxt;
  logic [SAMPLES_W-1:0] sample_count_r, sample_count_nxt;
  logic [SUM_W-1:0]     distance_sum_r, distance_sum_nxt;
  logic [HITS_W-1:0]    hit_count_r, hit_count_nxt;
  logic [DIVIDEND_W-1:0] cm_r, cm_nxt;
  logic                 hit_r, hit_nxt;
  logic                 last_r, last_nxt;
  logic [POS_W-1:0]     column_r, column_nxt;
  logic [HEIGHT_W-1:0]  height_r, height_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_user_r, out_user_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 cfg_wr;
  cfg_reg_t             cfg_sel;
  logic                 in_acc;
  logic                 out_free;
  logic [CM_PROD_W-1:0] cm_prod;
  logic [DIVIDEND_W-1:0] cm;
  logic                 cm_hit;
  logic [SUM_W-1:0]     sum_new;
  logic [HITS_W-1:0]    hits_new;
  logic [SAMPLES_W-1:0] count_new;
  logic [SAMPLES_W-1:0] group;
  logic                 group_end;
  logic [POS_W-1:0]     top;
  logic                 dir_down;
  logic [POS_W-1:0]     pos_step;

  srgda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_sel)
      REG_SAMPLES:  cfg_prdata = {{(32 - SAMPLES_W){1'b0}}, spp_r};
      REG_MIN_CM:   cfg_prdata = {{(32 - CM_W){1'b0}}, min_r};
      REG_MAX_CM:   cfg_prdata = {{(32 - CM_W){1'b0}}, max_r};
      REG_LAST_POS: cfg_prdata = {{(32 - POS_W){1'b0}}, last_pos_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r      <= SAMPLES_RST;
      min_r      <= MIN_CM_RST;
      max_r      <= MAX_CM_RST;
      last_pos_r <= LAST_POS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_SAMPLES:  spp_r      <= cfg_pwdata[SAMPLES_W-1:0];
        REG_MIN_CM:   min_r      <= cfg_pwdata[CM_W-1:0];
        REG_MAX_CM:   max_r      <= cfg_pwdata[CM_W-1:0];
        REG_LAST_POS: last_pos_r <= cfg_pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-sample datapath, valid in ST_ACCUM
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cm_prod   = CM_PROD_W'(in_tdata) * CM_PROD_W'(CM_RECIP);
  assign cm        = cm_r;
  assign cm_hit    = (cm >= DIVIDEND_W'(min_r)) && (cm <= DIVIDEND_W'(max_r));
  assign sum_new   = cm_hit ? distance_sum_r + cm[SUM_W-1:0] : distance_sum_r;
  assign hits_new  = cm_hit ? hit_count_r + 1'b1 : hit_count_r;
  assign count_new = sample_count_r + 1'b1;
  assign group     = (spp_r == '0) ? SAMPLES_W'(1) : spp_r;
  assign group_end = (count_new >= group) || (count_new == '0);

  assign top      = (last_pos_r > POS_W'(COLUMNS - 1)) ? POS_W'(COLUMNS - 1) : last_pos_r;
  assign dir_down = (position_r == '0) ? 1'b0 :
                    (position_r >= top) ? 1'b1 : moving_down_r;
  assign pos_step = dir_down ? position_r - 1'b1 : position_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_ACCUM;
      ST_ACCUM:   state_nxt = (group_end && hits_new != '0) ? ST_DIV_AVG : ST_FINISH;
      ST_DIV_AVG: if (div_rsp.done) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    div_req          = '0;
    position_nxt     = position_r;
    moving_down_nxt  = moving_down_r;
    sample_count_nxt = sample_count_r;
    distance_sum_nxt = distance_sum_r;
    hit_count_nxt    = hit_count_r;
    cm_nxt           = cm_r;
    hit_nxt          = hit_r;
    last_nxt         = last_r;
    column_nxt       = column_r;
    height_nxt       = height_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    out_user_nxt     = out_user_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) cm_nxt = DIVIDEND_W'(cm_prod >> CM_SHIFT);
      end
      ST_ACCUM: begin
        hit_nxt    = cm_hit;
        last_nxt   = group_end;
        column_nxt = '0;
        height_nxt = '0;
        if (group_end) begin
          position_nxt     = pos_step;
          moving_down_nxt  = dir_down;
          column_nxt       = pos_step;
          sample_count_nxt = '0;
          distance_sum_nxt = '0;
          hit_count_nxt    = '0;
          if (hits_new != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(sum_new);
            div_req.divisor  = DIVISOR_W'(hits_new);
          end
        end else begin
          sample_count_nxt = count_new;
          distance_sum_nxt = sum_new;
          hit_count_nxt    = hits_new;
        end
      end
      ST_DIV_AVG: begin
        if (div_rsp.done) height_nxt = div3_sat(div_rsp.quotient);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {height_r, column_r, hit_r};
          out_user_nxt  = last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      position_r     <= POSITION_RST;
      moving_down_r  <= 1'b0;
      sample_count_r <= '0;
      distance_sum_r <= '0;
      hit_count_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      position_r     <= position_nxt;
      moving_down_r  <= moving_down_nxt;
      sample_count_r <= sample_count_nxt;
      distance_sum_r <= distance_sum_nxt;
      hit_count_r    <= hit_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cm_r       <= cm_nxt;
    hit_r      <= hit_nxt;
    last_r     <= last_nxt;
    column_r   <= column_nxt;
    height_r   <= height_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  `SRGDA_ASSERT_IMP(a_hits_le_samples, 1'b1, hit_count_r <= sample_count_r)
  `SRGDA_ASSERT_IMP(a_div_done_expected, state_r == ST_IDLE || state_r == ST_ACCUM || state_r == ST_FINISH, !div_rsp.done)
  `SRGDA_ASSERT_NXT(a_accept_to_accum, in_tvalid && in_tready, state_r == ST_ACCUM)
  `SRGDA_ASSERT_IMP(a_plain_result_zero, out_tvalid && !out_tuser[0], out_tdata[7:1] == 7'd0)

endmodule
